// ===== src/goal_velocity_clamped_normalize_defines.svh =====
// ----------------------------------------------------------------------------
// goal_velocity_clamped_normalize_defines
// Assertion macros shared by the velocity pipeline.
// ----------------------------------------------------------------------------
`ifndef GOAL_VELOCITY_CLAMPED_NORMALIZE_DEFINES_SVH
`define GOAL_VELOCITY_CLAMPED_NORMALIZE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GVCN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GVCN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/gvcn_pkg.sv =====
// ----------------------------------------------------------------------------
// gvcn_pkg
// Widths, register indexes and stage side-band types for the velocity pipe.
// ----------------------------------------------------------------------------
`default_nettype none
package gvcn_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W   = $clog2(MAX_PARTICLES);
  localparam int C_W     = 32;            // Q16.16 coordinate
  localparam int SPD_W   = 31;            // preferred speed
  localparam int D_W     = C_W + 1;       // exact difference
  localparam int MAG_W   = D_W;           // |difference|
  localparam int SQ_W    = 2 * MAG_W;     // sum of three squares fits here
  localparam int SQ_STEPS = SQ_W / 2;     // one root bit per stage
  localparam int ROOT_W  = SQ_STEPS;
  localparam int REM_W   = ROOT_W + 3;
  localparam int LEN_W   = ROOT_W + 1;    // rounded length
  localparam int PROD_W  = MAG_W + SPD_W;
  localparam int DIV_STEPS = SPD_W;       // quotient never exceeds speed
  localparam int DR_W    = LEN_W + 1;
  localparam int AXES    = 3;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLAMP_ENABLE   = 8'd0,
    REG_FORMATION_MODE = 8'd1
  } cfg_reg_t;

  // carried alongside the square root
  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic [AXES-1:0][MAG_W-1:0]  mag;
    logic [AXES-1:0]             neg;
    logic [SPD_W-1:0]            pref;
    logic                        clamp;
  } sqr_side_t;

  // carried alongside the dividers
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [AXES-1:0]  neg;
    logic             zero;
  } div_side_t;

endpackage
`default_nettype wire

// ===== src/gvcn_if.sv =====
// ----------------------------------------------------------------------------
// gvcn channel interfaces
// Request channels for particle items, velocity results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface gvcn_in_if import gvcn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IDX_W-1:0]       particle_index;
  logic signed [C_W-1:0]  goal_x, goal_y, goal_z;
  logic signed [C_W-1:0]  final_x, final_y, final_z;
  logic signed [C_W-1:0]  pos_x, pos_y, pos_z;
  logic [SPD_W-1:0]       pref_speed;

  modport source (output valid, particle_index, goal_x, goal_y, goal_z,
                  final_x, final_y, final_z, pos_x, pos_y, pos_z, pref_speed,
                  input ready);
  modport sink (input valid, particle_index, goal_x, goal_y, goal_z,
                final_x, final_y, final_z, pos_x, pos_y, pos_z, pref_speed,
                output ready);
endinterface

interface gvcn_out_if import gvcn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [IDX_W-1:0]       out_index;
  logic signed [C_W-1:0]  vel_x, vel_y, vel_z;
  logic                   at_target;

  modport source (output valid, out_index, vel_x, vel_y, vel_z, at_target,
                  input ready);
  modport sink (input valid, out_index, vel_x, vel_y, vel_z, at_target,
                output ready);
endinterface

interface gvcn_cfg_if import gvcn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== src/gvcn_sqrt.sv =====
// ----------------------------------------------------------------------------
// gvcn_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module gvcn_sqrt import gvcn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_s,
  input  sqr_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [REM_W-1:0]  out_rem,
  output sqr_side_t         out_side
);

  logic              vld  [SQ_STEPS];
  logic [SQ_W-1:0]   sreg [SQ_STEPS];
  logic [ROOT_W-1:0] root [SQ_STEPS];
  logic [REM_W-1:0]  rem  [SQ_STEPS];
  sqr_side_t         side [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
    logic              v_i;
    logic [SQ_W-1:0]   s_i;
    logic [ROOT_W-1:0] q_i;
    logic [REM_W-1:0]  r_i;
    sqr_side_t         sd_i;
    logic [REM_W-1:0]  r_sh, trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_i  = in_valid;
      assign s_i  = in_s;
      assign q_i  = '0;
      assign r_i  = '0;
      assign sd_i = in_side;
    end else begin : g_rest
      assign v_i  = vld[k-1];
      assign s_i  = sreg[k-1];
      assign q_i  = root[k-1];
      assign r_i  = rem[k-1];
      assign sd_i = side[k-1];
    end

    // bring down the next pair of radicand bits, try (4q + 1)
    assign r_sh  = {r_i[REM_W-3:0], s_i[2*(SQ_STEPS-1-k)+1 -: 2]};
    assign trial = REM_W'({q_i, 2'b01});
    assign take  = (r_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sreg[k] <= s_i;
        root[k] <= {q_i[ROOT_W-2:0], take};
        rem[k]  <= take ? (r_sh - trial) : r_sh;
        side[k] <= sd_i;
      end
    end
  end

  assign out_valid = vld[SQ_STEPS-1];
  assign out_root  = root[SQ_STEPS-1];
  assign out_rem   = rem[SQ_STEPS-1];
  assign out_side  = side[SQ_STEPS-1];

endmodule
`default_nettype wire

// ===== src/gvcn_div.sv =====
// ----------------------------------------------------------------------------
// gvcn_div
// Three-lane pipelined restoring divider by the shared length, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module gvcn_div import gvcn_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [AXES-1:0][PROD_W-1:0] in_prod,
  input  logic [LEN_W-1:0]           in_len,
  input  div_side_t                  in_side,
  output logic                       out_valid,
  output logic [AXES-1:0][SPD_W-1:0] out_q,
  output logic [AXES-1:0][DR_W-1:0]  out_rem,
  output logic [LEN_W-1:0]           out_len,
  output div_side_t                  out_side
);

  logic                         vld  [DIV_STEPS];
  logic [LEN_W-1:0]             len  [DIV_STEPS];
  div_side_t                    side [DIV_STEPS];
  logic [AXES-1:0][PROD_W-1:0]  prod [DIV_STEPS];
  logic [AXES-1:0][SPD_W-1:0]   quo  [DIV_STEPS];
  logic [AXES-1:0][DR_W-1:0]    rem  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    logic                        v_i;
    logic [LEN_W-1:0]            l_i;
    div_side_t                   sd_i;
    logic [AXES-1:0][PROD_W-1:0] p_i;
    logic [AXES-1:0][SPD_W-1:0]  q_i;
    logic [AXES-1:0][DR_W-1:0]   r_i;
    logic [AXES-1:0][DR_W-1:0]   r_nx;
    logic [AXES-1:0]             take;

    if (k == 0) begin : g_first
      assign v_i  = in_valid;
      assign l_i  = in_len;
      assign sd_i = in_side;
      assign p_i  = in_prod;
      assign q_i  = '0;
      for (genvar a = 0; a < AXES; a++) begin : g_init
        // top bits of the product are already below the divisor
        assign r_i[a] = DR_W'(in_prod[a][PROD_W-1:DIV_STEPS]);
      end
    end else begin : g_rest
      assign v_i  = vld[k-1];
      assign l_i  = len[k-1];
      assign sd_i = side[k-1];
      assign p_i  = prod[k-1];
      assign q_i  = quo[k-1];
      assign r_i  = rem[k-1];
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
      logic [DR_W-1:0] r_sh;
      assign r_sh    = {r_i[a][LEN_W-1:0], p_i[a][DIV_STEPS-1-k]};
      assign take[a] = (r_sh >= DR_W'(l_i));
      assign r_nx[a] = take[a] ? (r_sh - DR_W'(l_i)) : r_sh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len[k]  <= l_i;
        side[k] <= sd_i;
        prod[k] <= p_i;
        rem[k]  <= r_nx;
        for (int a = 0; a < AXES; a++) begin
          quo[k][a] <= {q_i[a][SPD_W-2:0], take[a]};
        end
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_q     = quo[DIV_STEPS-1];
  assign out_rem   = rem[DIV_STEPS-1];
  assign out_len   = len[DIV_STEPS-1];
  assign out_side  = side[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== src/goal_velocity_clamped_normalize.sv =====
// ----------------------------------------------------------------------------
// goal_velocity_clamped_normalize
// Velocity toward the goal (or final goal) scaled to the preferred speed,
// optionally capped at the remaining distance.
// ----------------------------------------------------------------------------
// One request enters every clock unless the output stalls. The pipe has three
// front stages (difference, squares, sum), 33 square-root stages at one root
// bit each, two stages for length rounding and the speed product, 31 divider
// stages at one quotient bit each, and the output register. The whole pipe
// advances together and holds while a result waits at the output.
`default_nettype none
`include "goal_velocity_clamped_normalize_defines.svh"
module goal_velocity_clamped_normalize import gvcn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  gvcn_in_if.sink    in_ch,
  gvcn_out_if.source out_ch,
  gvcn_cfg_if.sink   cfg_ch
);

  logic en;
  logic clamp_enable, formation_mode;

  // register writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_enable   <= 1'b1;
      formation_mode <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_CLAMP_ENABLE:   clamp_enable   <= cfg_ch.data[0];
        REG_FORMATION_MODE: formation_mode <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: target select and exact difference
  logic signed [C_W-1:0] tgt [AXES];
  logic signed [C_W-1:0] pos [AXES];
  logic [AXES-1:0][MAG_W-1:0] mag_c;
  logic [AXES-1:0] neg_c;

  assign tgt[0] = formation_mode ? in_ch.final_x : in_ch.goal_x;
  assign tgt[1] = formation_mode ? in_ch.final_y : in_ch.goal_y;
  assign tgt[2] = formation_mode ? in_ch.final_z : in_ch.goal_z;
  assign pos[0] = in_ch.pos_x;
  assign pos[1] = in_ch.pos_y;
  assign pos[2] = in_ch.pos_z;

  always_comb begin
    logic [D_W-1:0] d;
    for (int a = 0; a < AXES; a++) begin
      d        = {tgt[a][C_W-1], tgt[a]} - {pos[a][C_W-1], pos[a]};
      neg_c[a] = d[D_W-1];
      mag_c[a] = d[D_W-1] ? (~d + D_W'(1)) : d;
    end
  end

  logic      a_v;
  sqr_side_t a_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_side.idx   <= in_ch.particle_index;
      a_side.mag   <= mag_c;
      a_side.neg   <= neg_c;
      a_side.pref  <= in_ch.pref_speed;
      a_side.clamp <= clamp_enable;
    end
  end

  // stage B: squares
  logic                      b_v;
  sqr_side_t                 b_side;
  logic [AXES-1:0][SQ_W-1:0] b_sq;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      for (int a = 0; a < AXES; a++) begin
        b_sq[a] <= a_side.mag[a] * a_side.mag[a];
      end
    end
  end

  // stage C: sum of squares
  logic            c_v;
  sqr_side_t       c_side;
  logic [SQ_W-1:0] c_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= b_side;
      c_s    <= b_sq[0] + b_sq[1] + b_sq[2];
    end
  end

  // square root
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  logic [REM_W-1:0]  sq_rem;
  sqr_side_t         sq_side;

  gvcn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_v),
    .in_s     (c_s),
    .in_side  (c_side),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_rem  (sq_rem),
    .out_side (sq_side)
  );

  // stage D: round length, pick speed
  logic [LEN_W-1:0] len_c;
  logic [SPD_W-1:0] spd_c;
  assign len_c = LEN_W'(sq_root) + LEN_W'(sq_rem > REM_W'(sq_root));
  assign spd_c = (sq_side.clamp && (len_c < LEN_W'(sq_side.pref)))
                 ? len_c[SPD_W-1:0] : sq_side.pref;

  logic                       d_v;
  logic [LEN_W-1:0]           d_len;
  logic [SPD_W-1:0]           d_spd;
  logic [AXES-1:0][MAG_W-1:0] d_mag;
  div_side_t                  d_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= sq_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_len       <= len_c;
      d_spd       <= spd_c;
      d_mag       <= sq_side.mag;
      d_side.idx  <= sq_side.idx;
      d_side.neg  <= sq_side.neg;
      d_side.zero <= (sq_root == '0);
    end
  end

  // stage E: magnitude times speed
  logic                        e_v;
  logic [LEN_W-1:0]            e_len;
  logic [AXES-1:0][PROD_W-1:0] e_prod;
  div_side_t                   e_side;
  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_len  <= d_len;
      e_side <= d_side;
      for (int a = 0; a < AXES; a++) begin
        e_prod[a] <= PROD_W'(d_mag[a]) * PROD_W'(d_spd);
      end
    end
  end

  // divide by length
  logic                       dv_v;
  logic [AXES-1:0][SPD_W-1:0] dv_q;
  logic [AXES-1:0][DR_W-1:0]  dv_rem;
  logic [LEN_W-1:0]           dv_len;
  div_side_t                  dv_side;

  gvcn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (e_v),
    .in_prod  (e_prod),
    .in_len   (e_len),
    .in_side  (e_side),
    .out_valid(dv_v),
    .out_q    (dv_q),
    .out_rem  (dv_rem),
    .out_len  (dv_len),
    .out_side (dv_side)
  );

  // output stage: round half away from zero, restore sign
  logic [AXES-1:0][C_W-1:0] vel_c;
  always_comb begin
    logic [C_W-1:0] m;
    logic           up;
    for (int a = 0; a < AXES; a++) begin
      up = ({dv_rem[a], 1'b0} >= (DR_W+1)'(dv_len));
      m  = C_W'(dv_q[a]) + C_W'(up);
      if (dv_side.zero) begin
        vel_c[a] = '0;
      end else begin
        vel_c[a] = dv_side.neg[a] ? (~m + C_W'(1)) : m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= dv_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.out_index <= dv_side.idx;
      out_ch.vel_x     <= vel_c[0];
      out_ch.vel_y     <= vel_c[1];
      out_ch.vel_z     <= vel_c[2];
      out_ch.at_target <= dv_side.zero;
    end
  end

  // checks
  `GVCN_ASSERT_NOW(a_target_zero, out_ch.valid && out_ch.at_target, out_ch.vel_x == '0 && out_ch.vel_y == '0 && out_ch.vel_z == '0, "at_target with nonzero velocity")
  `GVCN_ASSERT_NOW(a_stall_cause, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output backpressure")
  `GVCN_ASSERT_NEXT(a_hold_result, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.vel_x) && $stable(out_ch.out_index), "stalled result changed")

endmodule
`default_nettype wire
